/* rtl/rtp_pkg.sv */
// shared types, constants and fixed-point helpers of the ray-to-pixel projection unit
`default_nettype none
package rtp_pkg;

   localparam int FRACTION_BITS_DEFAULT = 24;
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_DATA_WIDTH = 64;

   // register indexes
   localparam logic [2:0] REG_SCALE_X         = 3'd0;
   localparam logic [2:0] REG_SCALE_Y         = 3'd1;
   localparam logic [2:0] REG_SKEW_SCALE      = 3'd2;
   localparam logic [2:0] REG_OFFSET_PAIR     = 3'd3;
   localparam logic [2:0] REG_RADIAL_K1       = 3'd4;
   localparam logic [2:0] REG_RADIAL_K2       = 3'd5;
   localparam logic [2:0] REG_RADIAL_K3       = 3'd6;
   localparam logic [2:0] REG_TANGENTIAL_PAIR = 3'd7;

   // saturated 32-bit value with its saturation flag
   typedef struct packed {
      logic               hit;
      logic signed [31:0] val;
   } sat_type;

   // clamp an exact 64-bit value to 32 bits
   function automatic sat_type rtp_sat(input logic signed [63:0] v);
      sat_type r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r.hit = 1'b1;
         r.val = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r.hit = 1'b1;
         r.val = -32'sh8000_0000;
      end else begin
         r.hit = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

   // round half up a full product by frac bits, then clamp
   function automatic sat_type rtp_round(input logic signed [63:0] p, input int frac);
      logic signed [63:0] b;
      b = p + (64'sd1 <<< (frac - 1));
      return rtp_sat(b >>> frac);
   endfunction

   // sign extend to the exact sum width
   function automatic logic signed [63:0] rtp_ext(input logic signed [31:0] a);
      return 64'(a);
   endfunction

endpackage
`default_nettype wire

/* rtl/rtp_channels.sv */
// request and response channel interfaces
`default_nettype none
interface rtp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] ray_x;
   logic signed [31:0] ray_y;
   logic signed [31:0] ray_z;
   modport source (output valid, ray_x, ray_y, ray_z, input ready);
   modport sink (input valid, ray_x, ray_y, ray_z, output ready);
endinterface

interface rtp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pixel_x;
   logic signed [31:0] pixel_y;
   logic               depth_was_zero;
   logic               clipped;
   modport source (output valid, pixel_x, pixel_y, depth_was_zero, clipped, input ready);
   modport sink (input valid, pixel_x, pixel_y, depth_was_zero, clipped, output ready);
endinterface
`default_nettype wire

/* rtl/ray_to_pixel_lens_projection_unit.sv */
// top level: ray to normalized pixel position with radial and tangential lens distortion
//
// Takes one ray per clock and returns one pixel word per ray, in order, in Q8.24 at the
// default FRACTION_BITS. The depth division is a restoring divider that settles one
// quotient bit per pipeline stage, followed by 17 stages of multiply, round and
// saturating-add. The whole pipeline stalls together when the result word is not taken,
// so a new ray is accepted whenever the output register is empty or being taken. A ray
// with zero depth gives (0,0) with depth_was_zero set. Registers sit at byte address
// 8*index; the user must write them only while the pipeline is empty, since the block
// itself does not enforce it.
`default_nettype none
module ray_to_pixel_lens_projection_unit #(
   parameter int FRACTION_BITS = rtp_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rtp_req_if.sink                                  req_port,
   rtp_rsp_if.source                                rsp_port,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [rtp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [rtp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [rtp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                     csr_pready
);

   localparam int NW = 32 + FRACTION_BITS;
   localparam int LAST = 16;
   localparam logic [NW-1:0] QMAX_POS = NW'(33'h0_7FFF_FFFF);
   localparam logic [NW-1:0] QMAX_NEG = NW'(33'h0_8000_0000);

   // configuration registers
   logic signed [31:0] scale_x_ff, scale_y_ff, skew_scale_ff;
   logic signed [31:0] k1_ff, k2_ff, k3_ff;
   logic [63:0]        offset_pair_ff, tangential_pair_ff;
   logic [2:0]         csr_index;
   logic               csr_write;

   assign csr_index  = csr_paddr[5:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff         <= 32'sd1 <<< FRACTION_BITS;
         scale_y_ff         <= 32'sd1 <<< FRACTION_BITS;
         skew_scale_ff      <= '0;
         offset_pair_ff     <= '0;
         k1_ff              <= '0;
         k2_ff              <= '0;
         k3_ff              <= '0;
         tangential_pair_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            rtp_pkg::REG_SCALE_X:         scale_x_ff <= csr_pwdata[31:0];
            rtp_pkg::REG_SCALE_Y:         scale_y_ff <= csr_pwdata[31:0];
            rtp_pkg::REG_SKEW_SCALE:      skew_scale_ff <= csr_pwdata[31:0];
            rtp_pkg::REG_OFFSET_PAIR:     offset_pair_ff <= csr_pwdata;
            rtp_pkg::REG_RADIAL_K1:       k1_ff <= csr_pwdata[31:0];
            rtp_pkg::REG_RADIAL_K2:       k2_ff <= csr_pwdata[31:0];
            rtp_pkg::REG_RADIAL_K3:       k3_ff <= csr_pwdata[31:0];
            rtp_pkg::REG_TANGENTIAL_PAIR: tangential_pair_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_index)
         rtp_pkg::REG_SCALE_X:         csr_prdata = {32'b0, scale_x_ff};
         rtp_pkg::REG_SCALE_Y:         csr_prdata = {32'b0, scale_y_ff};
         rtp_pkg::REG_SKEW_SCALE:      csr_prdata = {32'b0, skew_scale_ff};
         rtp_pkg::REG_OFFSET_PAIR:     csr_prdata = offset_pair_ff;
         rtp_pkg::REG_RADIAL_K1:       csr_prdata = {32'b0, k1_ff};
         rtp_pkg::REG_RADIAL_K2:       csr_prdata = {32'b0, k2_ff};
         rtp_pkg::REG_RADIAL_K3:       csr_prdata = {32'b0, k3_ff};
         rtp_pkg::REG_TANGENTIAL_PAIR: csr_prdata = tangential_pair_ff;
         default:                      csr_prdata = '0;
      endcase
   end

   logic signed [31:0] off_x, off_y, p1, p2;
   assign off_x = offset_pair_ff[63:32];
   assign off_y = offset_pair_ff[31:0];
   assign p1    = tangential_pair_ff[63:32];
   assign p2    = tangential_pair_ff[31:0];

   // global stall: everything moves when the output word is free or taken
   logic [LAST:0] vld_ff;
   logic          advance;
   assign advance        = !vld_ff[LAST] || rsp_port.ready;
   assign req_port.ready = advance;

   logic          dv_valid, dv_neg_x, dv_neg_y, dv_zero;
   logic [NW-1:0] dv_qx, dv_qy;

   rtp_divider #(.FRACTION_BITS(FRACTION_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_port.valid),
      .in_x      (req_port.ray_x),
      .in_y      (req_port.ray_y),
      .in_z      (req_port.ray_z),
      .out_valid (dv_valid),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_neg_x (dv_neg_x),
      .out_neg_y (dv_neg_y),
      .out_zero  (dv_zero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAST-1:0], dv_valid};
      end
   end

   // stage registers
   logic [LAST:0]      z_ff, c_ff;
   logic signed [31:0] u0_ff, v0_ff;
   logic signed [63:0] puu1_ff, pvv1_ff, puv1_ff;
   logic signed [31:0] u1_ff, v1_ff;
   logic signed [31:0] uu2_ff, vv2_ff, uv2_ff, u2_ff, v2_ff;
   logic signed [31:0] r2_3_ff, uu3_ff, vv3_ff, uv3_ff, u3_ff, v3_ff;
   logic signed [63:0] pr4_4_ff, pk1_4_ff;
   logic signed [31:0] r2_4_ff, tx4_ff, ty4_ff, uv4_ff, u4_ff, v4_ff;
   logic signed [31:0] r4_5_ff, k1r2_5_ff, r2_5_ff, tx5_ff, ty5_ff, uv5_ff, u5_ff, v5_ff;
   logic signed [63:0] pr6_6_ff, pk2_6_ff;
   logic signed [31:0] k1r2_6_ff, tx6_ff, ty6_ff, uv6_ff, u6_ff, v6_ff;
   logic signed [31:0] r6_7_ff, k2r4_7_ff, k1r2_7_ff, tx7_ff, ty7_ff, uv7_ff, u7_ff, v7_ff;
   logic signed [63:0] pk3_8_ff;
   logic signed [31:0] k1r2_8_ff, k2r4_8_ff, tx8_ff, ty8_ff, uv8_ff, u8_ff, v8_ff;
   logic signed [31:0] k3r6_9_ff, k1r2_9_ff, k2r4_9_ff, tx9_ff, ty9_ff, uv9_ff, u9_ff, v9_ff;
   logic signed [31:0] rad10_ff, tx10_ff, ty10_ff, uv10_ff, u10_ff, v10_ff;
   logic signed [63:0] pa11_ff, pb11_ff, pc11_ff, pd11_ff, pe11_ff, pf11_ff;
   logic signed [31:0] ra12_ff, rb12_ff, rc12_ff, rd12_ff, re12_ff, rf12_ff;
   logic signed [31:0] xd13_ff, yd13_ff;
   logic signed [63:0] pg14_ff, ph14_ff, pi14_ff;
   logic signed [31:0] rg15_ff, rh15_ff, ri15_ff;
   logic signed [31:0] px_ff, py_ff;

   // combinational results feeding the stages
   rtp_pkg::sat_type   u0_in, v0_in;
   rtp_pkg::sat_type   uu2_in, vv2_in, uv2_in, r2_3_in, tx4_in, ty4_in;
   rtp_pkg::sat_type   r4_5_in, k1r2_5_in, r6_7_in, k2r4_7_in, k3r6_9_in, rad10_in;
   rtp_pkg::sat_type   ra12_in, rb12_in, rc12_in, rd12_in, re12_in, rf12_in;
   rtp_pkg::sat_type   xd13_in, yd13_in, rg15_in, rh15_in, ri15_in, px_in, py_in;

   always_comb begin
      // saturate the quotients
      if (dv_neg_x) begin
         u0_in.hit = dv_qx > QMAX_NEG;
         u0_in.val = u0_in.hit ? -32'sh8000_0000 : 32'(-dv_qx[31:0]);
      end else begin
         u0_in.hit = dv_qx > QMAX_POS;
         u0_in.val = u0_in.hit ? 32'sh7FFF_FFFF : 32'(dv_qx[31:0]);
      end
      if (dv_neg_y) begin
         v0_in.hit = dv_qy > QMAX_NEG;
         v0_in.val = v0_in.hit ? -32'sh8000_0000 : 32'(-dv_qy[31:0]);
      end else begin
         v0_in.hit = dv_qy > QMAX_POS;
         v0_in.val = v0_in.hit ? 32'sh7FFF_FFFF : 32'(dv_qy[31:0]);
      end
      // squares and radius
      uu2_in  = rtp_pkg::rtp_round(puu1_ff, FRACTION_BITS);
      vv2_in  = rtp_pkg::rtp_round(pvv1_ff, FRACTION_BITS);
      uv2_in  = rtp_pkg::rtp_round(puv1_ff, FRACTION_BITS);
      r2_3_in = rtp_pkg::rtp_sat(rtp_pkg::rtp_ext(uu2_ff) + rtp_pkg::rtp_ext(vv2_ff));
      tx4_in  = rtp_pkg::rtp_sat(rtp_pkg::rtp_ext(r2_3_ff) + (rtp_pkg::rtp_ext(uu3_ff) <<< 1));
      ty4_in  = rtp_pkg::rtp_sat(rtp_pkg::rtp_ext(r2_3_ff) + (rtp_pkg::rtp_ext(vv3_ff) <<< 1));
      // radial polynomial
      r4_5_in   = rtp_pkg::rtp_round(pr4_4_ff, FRACTION_BITS);
      k1r2_5_in = rtp_pkg::rtp_round(pk1_4_ff, FRACTION_BITS);
      r6_7_in   = rtp_pkg::rtp_round(pr6_6_ff, FRACTION_BITS);
      k2r4_7_in = rtp_pkg::rtp_round(pk2_6_ff, FRACTION_BITS);
      k3r6_9_in = rtp_pkg::rtp_round(pk3_8_ff, FRACTION_BITS);
      rad10_in  = rtp_pkg::rtp_sat((64'sd1 <<< FRACTION_BITS) + rtp_pkg::rtp_ext(k1r2_9_ff)
                                   + rtp_pkg::rtp_ext(k2r4_9_ff)
                                   + rtp_pkg::rtp_ext(k3r6_9_ff));
      // distortion terms
      ra12_in = rtp_pkg::rtp_round(pa11_ff, FRACTION_BITS);
      rb12_in = rtp_pkg::rtp_round(pb11_ff, FRACTION_BITS);
      rc12_in = rtp_pkg::rtp_round(pc11_ff, FRACTION_BITS);
      rd12_in = rtp_pkg::rtp_round(pd11_ff, FRACTION_BITS);
      re12_in = rtp_pkg::rtp_round(pe11_ff, FRACTION_BITS);
      rf12_in = rtp_pkg::rtp_round(pf11_ff, FRACTION_BITS);
      xd13_in = rtp_pkg::rtp_sat(rtp_pkg::rtp_ext(ra12_ff) + (rtp_pkg::rtp_ext(rc12_ff) <<< 1)
                                 + rtp_pkg::rtp_ext(rd12_ff));
      yd13_in = rtp_pkg::rtp_sat(rtp_pkg::rtp_ext(rb12_ff) + rtp_pkg::rtp_ext(re12_ff)
                                 + (rtp_pkg::rtp_ext(rf12_ff) <<< 1));
      // image mapping
      rg15_in = rtp_pkg::rtp_round(pg14_ff, FRACTION_BITS);
      rh15_in = rtp_pkg::rtp_round(ph14_ff, FRACTION_BITS);
      ri15_in = rtp_pkg::rtp_round(pi14_ff, FRACTION_BITS);
      px_in   = rtp_pkg::rtp_sat(rtp_pkg::rtp_ext(rg15_ff) + rtp_pkg::rtp_ext(rh15_ff)
                                 + rtp_pkg::rtp_ext(off_x));
      py_in   = rtp_pkg::rtp_sat(rtp_pkg::rtp_ext(ri15_ff) + rtp_pkg::rtp_ext(off_y));
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (advance) begin
         z_ff[LAST:1] <= z_ff[LAST-1:0];
         z_ff[0]      <= dv_zero;
         // stage 0: quotients
         u0_ff   <= u0_in.val;
         v0_ff   <= v0_in.val;
         c_ff[0] <= u0_in.hit | v0_in.hit;
         // stage 1: squares
         puu1_ff <= u0_ff * u0_ff;
         pvv1_ff <= v0_ff * v0_ff;
         puv1_ff <= u0_ff * v0_ff;
         u1_ff   <= u0_ff;
         v1_ff   <= v0_ff;
         c_ff[1] <= c_ff[0];
         // stage 2
         uu2_ff  <= uu2_in.val;
         vv2_ff  <= vv2_in.val;
         uv2_ff  <= uv2_in.val;
         u2_ff   <= u1_ff;
         v2_ff   <= v1_ff;
         c_ff[2] <= c_ff[1] | uu2_in.hit | vv2_in.hit | uv2_in.hit;
         // stage 3: radius squared
         r2_3_ff <= r2_3_in.val;
         uu3_ff  <= uu2_ff;
         vv3_ff  <= vv2_ff;
         uv3_ff  <= uv2_ff;
         u3_ff   <= u2_ff;
         v3_ff   <= v2_ff;
         c_ff[3] <= c_ff[2] | r2_3_in.hit;
         // stage 4
         pr4_4_ff <= r2_3_ff * r2_3_ff;
         pk1_4_ff <= k1_ff * r2_3_ff;
         r2_4_ff  <= r2_3_ff;
         tx4_ff   <= tx4_in.val;
         ty4_ff   <= ty4_in.val;
         uv4_ff   <= uv3_ff;
         u4_ff    <= u3_ff;
         v4_ff    <= v3_ff;
         c_ff[4]  <= c_ff[3] | tx4_in.hit | ty4_in.hit;
         // stage 5
         r4_5_ff   <= r4_5_in.val;
         k1r2_5_ff <= k1r2_5_in.val;
         r2_5_ff   <= r2_4_ff;
         tx5_ff    <= tx4_ff;
         ty5_ff    <= ty4_ff;
         uv5_ff    <= uv4_ff;
         u5_ff     <= u4_ff;
         v5_ff     <= v4_ff;
         c_ff[5]   <= c_ff[4] | r4_5_in.hit | k1r2_5_in.hit;
         // stage 6
         pr6_6_ff  <= r4_5_ff * r2_5_ff;
         pk2_6_ff  <= k2_ff * r4_5_ff;
         k1r2_6_ff <= k1r2_5_ff;
         tx6_ff    <= tx5_ff;
         ty6_ff    <= ty5_ff;
         uv6_ff    <= uv5_ff;
         u6_ff     <= u5_ff;
         v6_ff     <= v5_ff;
         c_ff[6]   <= c_ff[5];
         // stage 7
         r6_7_ff   <= r6_7_in.val;
         k2r4_7_ff <= k2r4_7_in.val;
         k1r2_7_ff <= k1r2_6_ff;
         tx7_ff    <= tx6_ff;
         ty7_ff    <= ty6_ff;
         uv7_ff    <= uv6_ff;
         u7_ff     <= u6_ff;
         v7_ff     <= v6_ff;
         c_ff[7]   <= c_ff[6] | r6_7_in.hit | k2r4_7_in.hit;
         // stage 8
         pk3_8_ff  <= k3_ff * r6_7_ff;
         k1r2_8_ff <= k1r2_7_ff;
         k2r4_8_ff <= k2r4_7_ff;
         tx8_ff    <= tx7_ff;
         ty8_ff    <= ty7_ff;
         uv8_ff    <= uv7_ff;
         u8_ff     <= u7_ff;
         v8_ff     <= v7_ff;
         c_ff[8]   <= c_ff[7];
         // stage 9
         k3r6_9_ff <= k3r6_9_in.val;
         k1r2_9_ff <= k1r2_8_ff;
         k2r4_9_ff <= k2r4_8_ff;
         tx9_ff    <= tx8_ff;
         ty9_ff    <= ty8_ff;
         uv9_ff    <= uv8_ff;
         u9_ff     <= u8_ff;
         v9_ff     <= v8_ff;
         c_ff[9]   <= c_ff[8] | k3r6_9_in.hit;
         // stage 10: radial factor
         rad10_ff <= rad10_in.val;
         tx10_ff  <= tx9_ff;
         ty10_ff  <= ty9_ff;
         uv10_ff  <= uv9_ff;
         u10_ff   <= u9_ff;
         v10_ff   <= v9_ff;
         c_ff[10] <= c_ff[9] | rad10_in.hit;
         // stage 11: distortion products
         pa11_ff  <= rad10_ff * u10_ff;
         pb11_ff  <= rad10_ff * v10_ff;
         pc11_ff  <= p1 * uv10_ff;
         pd11_ff  <= p2 * tx10_ff;
         pe11_ff  <= p1 * ty10_ff;
         pf11_ff  <= p2 * uv10_ff;
         c_ff[11] <= c_ff[10];
         // stage 12
         ra12_ff  <= ra12_in.val;
         rb12_ff  <= rb12_in.val;
         rc12_ff  <= rc12_in.val;
         rd12_ff  <= rd12_in.val;
         re12_ff  <= re12_in.val;
         rf12_ff  <= rf12_in.val;
         c_ff[12] <= c_ff[11] | ra12_in.hit | rb12_in.hit | rc12_in.hit
                     | rd12_in.hit | re12_in.hit | rf12_in.hit;
         // stage 13: distorted point
         xd13_ff  <= xd13_in.val;
         yd13_ff  <= yd13_in.val;
         c_ff[13] <= c_ff[12] | xd13_in.hit | yd13_in.hit;
         // stage 14: scale and skew products
         pg14_ff  <= scale_x_ff * xd13_ff;
         ph14_ff  <= skew_scale_ff * yd13_ff;
         pi14_ff  <= scale_y_ff * yd13_ff;
         c_ff[14] <= c_ff[13];
         // stage 15
         rg15_ff  <= rg15_in.val;
         rh15_ff  <= rh15_in.val;
         ri15_ff  <= ri15_in.val;
         c_ff[15] <= c_ff[14] | rg15_in.hit | rh15_in.hit | ri15_in.hit;
         // stage 16: output word, zero depth forces the origin
         px_ff    <= z_ff[LAST-1] ? 32'sd0 : px_in.val;
         py_ff    <= z_ff[LAST-1] ? 32'sd0 : py_in.val;
         c_ff[16] <= !z_ff[LAST-1] && (c_ff[15] | px_in.hit | py_in.hit);
      end
   end

   assign rsp_port.valid          = vld_ff[LAST];
   assign rsp_port.pixel_x        = px_ff;
   assign rsp_port.pixel_y        = py_ff;
   assign rsp_port.depth_was_zero = z_ff[LAST];
   assign rsp_port.clipped        = c_ff[LAST];

endmodule
`default_nettype wire

/* rtl/rtp_divider.sv */
// pipelined restoring divider: two dividends over one shared depth, one quotient bit per stage
`default_nettype none
module rtp_divider #(
   parameter int FRACTION_BITS = rtp_pkg::FRACTION_BITS_DEFAULT,
   localparam int NW = 32 + FRACTION_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] in_x,
   input  wire logic signed [31:0] in_y,
   input  wire logic signed [31:0] in_z,
   output logic                    out_valid,
   output logic [NW-1:0]           out_qx,
   output logic [NW-1:0]           out_qy,
   output logic                    out_neg_x,
   output logic                    out_neg_y,
   output logic                    out_zero
);

   logic          valid_ff [NW];
   logic [31:0]   rem_x_ff [NW];
   logic [31:0]   rem_y_ff [NW];
   logic [NW-1:0] num_x_ff [NW];
   logic [NW-1:0] num_y_ff [NW];
   logic [NW-1:0] q_x_ff   [NW];
   logic [NW-1:0] q_y_ff   [NW];
   logic [31:0]   den_ff   [NW];
   logic          neg_x_ff [NW];
   logic          neg_y_ff [NW];
   logic          zero_ff  [NW];

   logic [31:0] mag_x, mag_y, mag_z;

   // magnitudes of the operands
   always_comb begin
      mag_x = in_x[31] ? 32'(-in_x) : 32'(in_x);
      mag_y = in_y[31] ? 32'(-in_y) : 32'(in_y);
      mag_z = in_z[31] ? 32'(-in_z) : 32'(in_z);
   end

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic          vld_src;
      logic [31:0]   rx_src, ry_src, den_src;
      logic [NW-1:0] nx_src, ny_src, qx_src, qy_src;
      logic          ngx_src, ngy_src, z_src;
      logic [32:0]   shx, shy;
      logic          gex, gey;
      logic [31:0]   rem_x_in, rem_y_in;

      // stage operands: the ports for the first stage, else the previous stage
      if (s == 0) begin : g_first
         always_comb begin
            vld_src = in_valid;
            rx_src  = '0;
            ry_src  = '0;
            nx_src  = {mag_x, {FRACTION_BITS{1'b0}}};
            ny_src  = {mag_y, {FRACTION_BITS{1'b0}}};
            qx_src  = '0;
            qy_src  = '0;
            den_src = mag_z;
            ngx_src = in_x[31] ^ in_z[31];
            ngy_src = in_y[31] ^ in_z[31];
            z_src   = (in_z == 32'sd0);
         end
      end else begin : g_next
         always_comb begin
            vld_src = valid_ff[s-1];
            rx_src  = rem_x_ff[s-1];
            ry_src  = rem_y_ff[s-1];
            nx_src  = num_x_ff[s-1];
            ny_src  = num_y_ff[s-1];
            qx_src  = q_x_ff[s-1];
            qy_src  = q_y_ff[s-1];
            den_src = den_ff[s-1];
            ngx_src = neg_x_ff[s-1];
            ngy_src = neg_y_ff[s-1];
            z_src   = zero_ff[s-1];
         end
      end

      // one trial subtraction per lane
      always_comb begin
         shx      = {rx_src, nx_src[NW-1]};
         shy      = {ry_src, ny_src[NW-1]};
         gex      = shx >= {1'b0, den_src};
         gey      = shy >= {1'b0, den_src};
         rem_x_in = gex ? 32'(shx - {1'b0, den_src}) : shx[31:0];
         rem_y_in = gey ? 32'(shy - {1'b0, den_src}) : shy[31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_x_ff[s] <= rem_x_in;
            rem_y_ff[s] <= rem_y_in;
            num_x_ff[s] <= {nx_src[NW-2:0], 1'b0};
            num_y_ff[s] <= {ny_src[NW-2:0], 1'b0};
            q_x_ff[s]   <= {qx_src[NW-2:0], gex};
            q_y_ff[s]   <= {qy_src[NW-2:0], gey};
            den_ff[s]   <= den_src;
            neg_x_ff[s] <= ngx_src;
            neg_y_ff[s] <= ngy_src;
            zero_ff[s]  <= z_src;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_qx    = q_x_ff[NW-1];
   assign out_qy    = q_y_ff[NW-1];
   assign out_neg_x = neg_x_ff[NW-1];
   assign out_neg_y = neg_y_ff[NW-1];
   assign out_zero  = zero_ff[NW-1];

endmodule
`default_nettype wire
